/* src/bmf_pkg.sv */
// package for the clipped-border box mean filter
// constants, register indexes and the sequencer state type; no dependencies
`default_nettype none
package bmf_pkg;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_RADIUS  = 8;
    localparam int PIXEL_BITS  = 16;
    localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(STORE_ROWS);
    localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
    localparam int CFG_W       = 11;
    localparam int RAD_W       = 4;
    localparam int POS_W       = 22;
    localparam int SUM_W       = 25;
    localparam int CNT_W       = 9;
    localparam int DVD_W       = SUM_W + 8;
    localparam int MEAN_W      = 24;
    localparam int OUT_POS_W   = 10;

    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_WINDOW_RADIUS = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CALC   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_WSUM   = 7'b0001000,
        S_WTAIL  = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;
endpackage
`default_nettype wire

/* src/bmf_if.sv */
// stream channels of the box mean filter: pixel input and mean output
// depends on bmf_pkg
`default_nettype none
interface bmf_in_if import bmf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [PIXEL_BITS-1:0] pixel;
    modport source (output valid, operation, pixel, input ready);
    modport sink   (input valid, operation, pixel, output ready);
endinterface

interface bmf_out_if import bmf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MEAN_W-1:0]    mean_value;
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;
    logic                 last_of_frame;
    modport source (output valid, mean_value, out_row, out_col, last_of_frame, input ready);
    modport sink   (input valid, mean_value, out_row, out_col, last_of_frame, output ready);
endinterface
`default_nettype wire

/* src/bmf_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module bmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* src/box_mean_filter_clipped_border.sv */
// top level of the clipped-border box mean filter: sequencer, window sweep, divider
// depends on bmf_pkg, bmf_if and bmf_ram
//
//  channel  dir  beat payload
//  i_in     in   operation, pixel
//  o_out    out  mean_value, out_row, out_col, last_of_frame
//  i_cfg_*  in   index, data (width, height, radius)
//
// an item with no result passes S_IDLE, S_CALC and S_DECIDE; one with a result is
// paced by the line store read port (one window pixel per cycle) and the
// bit-serial divider (33 steps)
// reset is synchronous; the line store has no clearing pass
// a new item is taken while a result waits in the output register
`default_nettype none
module box_mean_filter_clipped_border import bmf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    bmf_in_if.sink                i_in,
    bmf_out_if.source             o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [RAD_W-1:0] r_cfg_rad;
    logic [CFG_W-1:0] w_eff, h_eff;
    logic [RAD_W-1:0] rad_eff;

    logic [COL_W-1:0] r_in_col, n_in_col, r_em_col, n_em_col;
    logic [CFG_W-1:0] r_in_row, n_in_row, r_em_row, n_em_row;
    logic [ROW_W-1:0] r_in_mod, n_in_mod, r_em_mod, n_em_mod;

    logic                  r_op;
    logic [PIXEL_BITS-1:0] r_pix;
    logic [POS_W-1:0]      r_total, r_delay, r_v, r_e;

    logic [CFG_W-1:0] r_r0, r_r1;
    logic [COL_W-1:0] r_c0, r_c1;
    logic [ROW_W-1:0] r_ymod;
    logic [CFG_W-1:0] r_y;
    logic [COL_W-1:0] r_x;
    logic             r_rd_valid;
    logic [SUM_W-1:0] r_sum;
    logic             r_last;
    logic [CNT_W-1:0] r_count;
    logic [DVD_W-1:0] r_dvd;
    logic [CNT_W-1:0] r_rem;
    logic [5:0]       r_bit;

    logic                 r_o_valid;
    logic [MEAN_W-1:0]    r_o_mean;
    logic [OUT_POS_W-1:0] r_o_row, r_o_col;
    logic                 r_o_last;

    logic [PIXEL_BITS-1:0] rdata;
    logic                  mem_we;

    // decision terms
    logic             in_frame, emit, restart_now;
    logic [CFG_W:0]   r_lo, r_hi, c_lo, c_hi, row_plus, col_plus;
    logic [RAD_W-1:0] d_rows;
    logic [ROW_W:0]   mod_tmp;
    logic [ROW_W-1:0] r0mod;
    logic             empty;
    logic [COL_W:0]   in_col_inc, em_col_inc;
    logic [SUM_W-1:0] sum_add;
    logic [CNT_W:0]   rem_sh;
    logic             ge;
    logic             out_load;

    assign w_eff   = (r_cfg_w == '0) ? CFG_W'(1) :
                     (r_cfg_w > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : r_cfg_w;
    assign h_eff   = (r_cfg_h == '0) ? CFG_W'(1) :
                     (r_cfg_h > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : r_cfg_h;
    assign rad_eff = (r_cfg_rad > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_cfg_rad;

    assign in_frame    = r_v < r_total;
    assign emit        = (r_e < r_total) && (r_v >= r_e + r_delay);
    assign restart_now = (r_e >= r_total) && (r_v + POS_W'(1) >= r_total);

    // clipped window bounds of the next emitted position
    assign row_plus = {1'b0, r_em_row} + (CFG_W+1)'(rad_eff);
    assign col_plus = (CFG_W+1)'(r_em_col) + (CFG_W+1)'(rad_eff);
    assign r_lo = (r_em_row >= CFG_W'(rad_eff)) ? {1'b0, r_em_row} - (CFG_W+1)'(rad_eff) : '0;
    assign r_hi = (row_plus < (CFG_W+1)'(h_eff)) ? row_plus : (CFG_W+1)'(h_eff) - 1'b1;
    assign c_lo = ((CFG_W+1)'(r_em_col) >= (CFG_W+1)'(rad_eff)) ?
                  (CFG_W+1)'(r_em_col) - (CFG_W+1)'(rad_eff) : '0;
    assign c_hi = (col_plus < (CFG_W+1)'(w_eff)) ? col_plus : (CFG_W+1)'(w_eff) - 1'b1;
    assign empty = (r_lo > r_hi) || (c_lo > c_hi);
    assign d_rows  = (r_em_row >= CFG_W'(rad_eff)) ? rad_eff : r_em_row[RAD_W-1:0];
    assign mod_tmp = ((ROW_W+1)'(r_em_mod) >= (ROW_W+1)'(d_rows)) ?
                     (ROW_W+1)'(r_em_mod) - (ROW_W+1)'(d_rows) :
                     (ROW_W+1)'(r_em_mod) + (ROW_W+1)'(STORE_ROWS) - (ROW_W+1)'(d_rows);
    assign r0mod = mod_tmp[ROW_W-1:0];

    assign in_col_inc = (COL_W+1)'(r_in_col) + 1'b1;
    assign em_col_inc = (COL_W+1)'(r_em_col) + 1'b1;
    assign sum_add    = r_sum + (r_rd_valid ? SUM_W'(rdata) : '0);
    assign rem_sh     = {r_rem, r_dvd[DVD_W-1]};
    assign ge         = rem_sh >= (CNT_W+1)'(r_count);
    assign out_load   = (r_state == S_OUT) && (!r_o_valid || o_out.ready);
    assign mem_we     = (r_state == S_DECIDE) && in_frame && (r_op == OP_PIXEL);

    bmf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(STORE_DEPTH)) u_line_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ($clog2(STORE_DEPTH)'({r_in_mod, r_in_col})),
        .i_wdata (r_pix),
        .i_raddr ($clog2(STORE_DEPTH)'({r_ymod, r_x})),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_in_mod = r_in_mod;
        n_em_col = r_em_col;
        n_em_row = r_em_row;
        n_em_mod = r_em_mod;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_CALC;
            end
            S_CALC: n_state = S_DECIDE;
            S_DECIDE: begin
                if (in_frame && (r_op == OP_DRAIN)) begin
                    n_state = S_IDLE;
                end else begin
                    if (in_col_inc >= (COL_W+1)'(w_eff)) begin
                        n_in_col = '0;
                        n_in_row = r_in_row + 1'b1;
                        n_in_mod = (r_in_mod == ROW_W'(STORE_ROWS - 1)) ? '0 : r_in_mod + 1'b1;
                    end else begin
                        n_in_col = in_col_inc[COL_W-1:0];
                    end
                    if (emit) begin
                        n_state = empty ? S_OUT : S_WSUM;
                    end else begin
                        n_state = S_IDLE;
                        if (restart_now) begin
                            n_in_col = '0; n_in_row = '0; n_in_mod = '0;
                            n_em_col = '0; n_em_row = '0; n_em_mod = '0;
                        end
                    end
                end
            end
            S_WSUM: begin
                if ((r_x == r_c1) && (r_y == r_r1)) n_state = S_WTAIL;
            end
            S_WTAIL: n_state = S_DIV;
            S_DIV: begin
                if (r_bit == 6'(DVD_W - 1)) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                    if (em_col_inc >= (COL_W+1)'(w_eff)) begin
                        n_em_col = '0;
                        n_em_row = r_em_row + 1'b1;
                        n_em_mod = (r_em_mod == ROW_W'(STORE_ROWS - 1)) ? '0 : r_em_mod + 1'b1;
                    end else begin
                        n_em_col = em_col_inc[COL_W-1:0];
                    end
                    if (r_last) begin
                        n_in_col = '0; n_in_row = '0; n_in_mod = '0;
                        n_em_col = '0; n_em_row = '0; n_em_mod = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg_w   <= CFG_W'(MAX_WIDTH);
            r_cfg_h   <= CFG_W'(MAX_HEIGHT);
            r_cfg_rad <= RAD_W'(2);
            r_in_col  <= '0; r_in_row <= '0; r_in_mod <= '0;
            r_em_col  <= '0; r_em_row <= '0; r_em_mod <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_col <= n_in_col; r_in_row <= n_in_row; r_in_mod <= n_in_mod;
            r_em_col <= n_em_col; r_em_row <= n_em_row; r_em_mod <= n_em_mod;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:   r_cfg_w   <= i_cfg_data;
                    CFG_IMAGE_HEIGHT:  r_cfg_h   <= i_cfg_data;
                    CFG_WINDOW_RADIUS: r_cfg_rad <= i_cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) r_o_valid <= 1'b1;
            else if (o_out.ready) r_o_valid <= 1'b0;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op  <= i_in.operation;
                r_pix <= i_in.pixel;
            end
            S_CALC: begin
                r_total <= POS_W'(w_eff * h_eff);
                r_delay <= POS_W'(rad_eff * w_eff) + POS_W'(rad_eff);
                r_v     <= POS_W'(r_in_row * w_eff) + POS_W'(r_in_col);
                r_e     <= POS_W'(r_em_row * w_eff) + POS_W'(r_em_col);
            end
            S_DECIDE: begin
                r_last     <= r_e == r_total - 1'b1;
                r_r0       <= r_lo[CFG_W-1:0];
                r_r1       <= r_hi[CFG_W-1:0];
                r_c0       <= c_lo[COL_W-1:0];
                r_c1       <= c_hi[COL_W-1:0];
                r_y        <= r_lo[CFG_W-1:0];
                r_x        <= c_lo[COL_W-1:0];
                r_ymod     <= r0mod;
                r_sum      <= '0;
                r_rd_valid <= 1'b0;
                r_dvd      <= '0;
            end
            S_WSUM: begin
                r_rd_valid <= 1'b1;
                r_sum      <= sum_add;
                if (r_x == r_c1) begin
                    r_x <= r_c0;
                    if (r_y != r_r1) begin
                        r_y    <= r_y + 1'b1;
                        r_ymod <= (r_ymod == ROW_W'(STORE_ROWS - 1)) ? '0 : r_ymod + 1'b1;
                    end
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            S_WTAIL: begin
                r_count <= CNT_W'((ROW_W+1)'(r_r1 - r_r0 + 1'b1) *
                                  (ROW_W+1)'(r_c1 - r_c0 + 1'b1));
                r_dvd   <= {sum_add, 8'b0};
                r_rem   <= '0;
                r_bit   <= '0;
            end
            S_DIV: begin
                r_rem <= ge ? CNT_W'(rem_sh - (CNT_W+1)'(r_count)) : rem_sh[CNT_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], ge};
                r_bit <= r_bit + 1'b1;
            end
            default: ;
        endcase
        if (out_load) begin
            r_o_mean <= r_dvd[MEAN_W-1:0];
            r_o_row  <= r_em_row[OUT_POS_W-1:0];
            r_o_col  <= r_em_col[OUT_POS_W-1:0];
            r_o_last <= r_last;
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_o_valid;
    assign o_out.mean_value    = r_o_mean;
    assign o_out.out_row       = r_o_row;
    assign o_out.out_col       = r_o_col;
    assign o_out.last_of_frame = r_o_last;
endmodule
`default_nettype wire

/* src/bmf_checker.sv */
// port-level checks of the box mean filter, bound to the top level
// depends on bmf_pkg and box_mean_filter_clipped_border
`default_nettype none
module bmf_checker import bmf_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [MEAN_W-1:0]    i_out_mean,
    input wire logic [OUT_POS_W-1:0] i_out_col
);
    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // one item at a time: a taken beat closes the input for the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted beat");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_mean) && $stable(i_out_col)))
        else $error("stalled output beat changed");
endmodule

bind box_mean_filter_clipped_border bmf_checker u_bmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_mean  (o_out.mean_value),
    .i_out_col   (o_out.out_col)
);
`default_nettype wire
